// ===== rtl/mbw_pkg.sv =====
// Package for the maze backtracker walk core: sizes, item layouts, result kinds
// and small helper functions for neighbour addressing and selection.
// Depends on nothing; mbw_pick, the core and the testbench import it.
package mbw_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int COORD_W    = $clog2(MAX_SIDE);
	localparam int CELL_W     = 2 * COORD_W;
	localparam int CELLS      = MAX_SIDE * MAX_SIDE;
	localparam int CNT_W      = CELL_W + 1;
	localparam int SIDE_W     = 7;
	localparam int RAND_W     = 8;
	localparam int EPOCH_W    = 8;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIDE_W;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CELL_W-1:0]  cell_t;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;
	localparam logic [SIDE_W-1:0]    SIDE_RESET      = 7'd30;

	typedef enum logic [1:0] {
		KIND_EDGE  = 2'd0,
		KIND_BACK  = 2'd1,
		KIND_DONE  = 2'd2,
		KIND_START = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		DIR_PX = 2'd0,
		DIR_PY = 2'd1,
		DIR_MX = 2'd2,
		DIR_MY = 2'd3
	} dir_t;

	typedef struct packed {
		logic               mode;
		coord_t             start_x;
		coord_t             start_y;
		logic [RAND_W-1:0]  rand_value;
	} cmd_t;

	typedef struct packed {
		kind_t  kind;
		coord_t from_x;
		coord_t from_y;
		coord_t to_x;
		coord_t to_y;
	} res_t;

	typedef struct packed {
		logic   found;
		coord_t x;
		coord_t y;
	} pick_t;

	function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] v);
		if (v == '0) begin
			return SIDE_W'(1);
		end
		if (v > SIDE_W'(MAX_SIDE)) begin
			return SIDE_W'(MAX_SIDE);
		end
		return v;
	endfunction

	// Cell address is row-major: the row in the upper half, the column in the lower.
	function automatic cell_t nb_cell(input dir_t d, input coord_t x, input coord_t y);
		case (d)
			DIR_PX:  return {y, coord_t'(x + 1'b1)};
			DIR_PY:  return {coord_t'(y + 1'b1), x};
			DIR_MX:  return {y, coord_t'(x - 1'b1)};
			DIR_MY:  return {coord_t'(y - 1'b1), x};
			default: return {y, x};
		endcase
	endfunction

	// Residue modulo three, using the fact that four is one modulo three.
	function automatic logic [1:0] mod3(input logic [RAND_W-1:0] r);
		logic [3:0] s;
		s = 4'(r[1:0]) + 4'(r[3:2]) + 4'(r[5:4]) + 4'(r[7:6]);
		case (s)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12: return 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10:       return 2'd1;
			default:                       return 2'd2;
		endcase
	endfunction

endpackage

// ===== rtl/mbw_stream_if.sv =====
// Valid/ready stream channel carrying one item of a packed payload type.
// Depends on nothing; the payload types come from mbw_pkg where it is used.
interface mbw_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mbw_pick.sv =====
// Chooses one open neighbour of the current cell from the random value.
// Depends on mbw_pkg.
module mbw_pick
	import mbw_pkg::*;
(
	input  logic [3:0]        open_dirs,
	input  logic [RAND_W-1:0] rand_value,
	input  coord_t            cur_x,
	input  coord_t            cur_y,
	output pick_t             pick
);

	logic [2:0] n;
	logic [1:0] sel;
	logic [1:0] seen;
	logic       hit;
	dir_t       dir;

	always_comb begin
		n = 3'($countones(open_dirs));
		case (n)
			3'd2:    sel = {1'b0, rand_value[0]};
			3'd3:    sel = mod3(rand_value);
			3'd4:    sel = rand_value[1:0];
			default: sel = 2'd0;
		endcase
		seen = 2'd0;
		hit  = 1'b0;
		dir  = DIR_PX;
		for (int k = 0; k < 4; k++) begin
			if (open_dirs[k]) begin
				if (!hit && seen == sel) begin
					hit = 1'b1;
					dir = dir_t'(k[1:0]);
				end
				seen = seen + 2'd1;
			end
		end
		pick.found        = hit;
		{pick.y, pick.x}  = nb_cell(dir, cur_x, cur_y);
	end

endmodule

// ===== rtl/maze_backtracker_walk_core.sv =====
// Top level of the maze backtracker walk core: sequencer, visited store and trail stack.
// Depends on mbw_pkg, mbw_stream_if and mbw_pick.
//
// A start item goes from ST_START to ST_EMIT; the first start after reset and every
// 255th start after it add a clearing pass over all 4096 cells of the visited store.
// A step reads neighbours in ST_NB, picks in ST_EVAL, reads the trail in ST_POP on a
// backtrack, and goes straight to ST_EMIT with an empty trail. The visited store's
// single read port, reading the four neighbours one per cycle, and the trail read set
// the step time. A new item is taken while a result still waits on the output register.
module maze_backtracker_walk_core
	import mbw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	mbw_stream_if.sink            cmd,
	mbw_stream_if.source          res
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_SWEEP = 7'b0000010,
		ST_START = 7'b0000100,
		ST_NB    = 7'b0001000,
		ST_EVAL  = 7'b0010000,
		ST_POP   = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [SIDE_W-1:0]   width_q;
	logic [SIDE_W-1:0]   height_q;
	coord_t              cur_x_q;
	coord_t              cur_y_q;
	logic [CNT_W-1:0]    count_q;
	logic [EPOCH_W-1:0]  epoch_q;
	cell_t               sweep_q;
	logic [2:0]          nb_q;
	logic                rd_vld_s1;
	logic [1:0]          rd_k_s1;
	logic [3:0]          open_q;
	logic [RAND_W-1:0]   rand_q;
	coord_t              sx_q;
	coord_t              sy_q;
	res_t                pend_q;
	res_t                out_q;
	logic                out_valid_q;

	logic [EPOCH_W-1:0]  vis_mem [CELLS];
	logic [EPOCH_W-1:0]  vis_rd_q;
	cell_t               trail_mem [CELLS];
	cell_t               trail_rd_q;

	logic                vis_we;
	cell_t               vis_wa;
	logic [EPOCH_W-1:0]  vis_wd;
	cell_t               vis_ra;
	logic                trail_we;
	cell_t               trail_wa;
	cell_t               trail_wd;
	cell_t               trail_ra;
	logic [CNT_W-1:0]    cnt_m2;

	logic [SIDE_W-1:0]   w_eff;
	logic [SIDE_W-1:0]   h_eff;
	coord_t              wm1;
	coord_t              hm1;
	coord_t              sx;
	coord_t              sy;
	logic [3:0]          in_grid;
	logic                accept;
	logic                emit_go;
	pick_t               pick;

	mbw_pick u_pick (
		.open_dirs  (open_q),
		.rand_value (rand_q),
		.cur_x      (cur_x_q),
		.cur_y      (cur_y_q),
		.pick       (pick)
	);

	assign w_eff   = eff_side(width_q);
	assign h_eff   = eff_side(height_q);
	assign wm1     = coord_t'(w_eff - SIDE_W'(1));
	assign hm1     = coord_t'(h_eff - SIDE_W'(1));
	assign sx      = (cmd.data.start_x > wm1) ? wm1 : cmd.data.start_x;
	assign sy      = (cmd.data.start_y > hm1) ? hm1 : cmd.data.start_y;
	assign in_grid = {cur_y_q != '0, cur_x_q != '0,
		(SIDE_W'(cur_y_q) + SIDE_W'(1)) < h_eff,
		(SIDE_W'(cur_x_q) + SIDE_W'(1)) < w_eff};

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && (state_q == ST_IDLE);
	assign emit_go   = (state_q == ST_EMIT) && (!out_valid_q || res.ready);
	assign res.valid = out_valid_q;
	assign res.data  = out_q;

	assign cnt_m2   = count_q - CNT_W'(2);
	assign trail_ra = cnt_m2[CELL_W-1:0];
	assign vis_ra   = nb_cell(dir_t'(nb_q[1:0]), cur_x_q, cur_y_q);

	always_comb begin
		vis_we   = 1'b0;
		vis_wa   = sweep_q;
		vis_wd   = '0;
		trail_we = 1'b0;
		trail_wa = count_q[CELL_W-1:0];
		trail_wd = {pick.y, pick.x};
		case (state_q)
			ST_SWEEP: begin
				vis_we = 1'b1;
			end
			ST_START: begin
				vis_we   = 1'b1;
				vis_wa   = {sy_q, sx_q};
				vis_wd   = epoch_q;
				trail_we = 1'b1;
				trail_wa = '0;
				trail_wd = {sy_q, sx_q};
			end
			ST_EVAL: begin
				if (pick.found) begin
					vis_we   = 1'b1;
					vis_wa   = {pick.y, pick.x};
					vis_wd   = epoch_q;
					trail_we = !count_q[CNT_W-1];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_wa] <= vis_wd;
		end
		vis_rd_q <= vis_mem[vis_ra];
	end

	always_ff @(posedge clk) begin
		if (trail_we) begin
			trail_mem[trail_wa] <= trail_wd;
		end
		trail_rd_q <= trail_mem[trail_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			width_q     <= SIDE_RESET;
			height_q    <= SIDE_RESET;
			cur_x_q     <= '0;
			cur_y_q     <= '0;
			count_q     <= '0;
			epoch_q     <= '0;
			sweep_q     <= '0;
			nb_q        <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_GRID_WIDTH:  width_q  <= cfg_data;
					CFG_GRID_HEIGHT: height_q <= cfg_data;
					default: begin
					end
				endcase
			end
			rd_vld_s1 <= (state_q == ST_NB) && !nb_q[2];
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!cmd.data.mode) begin
							if (epoch_q == '0 || epoch_q == '1) begin
								sweep_q <= '0;
								state_q <= ST_SWEEP;
							end else begin
								epoch_q <= epoch_q + 1'b1;
								state_q <= ST_START;
							end
						end else if (count_q == '0) begin
							state_q <= ST_EMIT;
						end else begin
							nb_q    <= '0;
							state_q <= ST_NB;
						end
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == '1) begin
						epoch_q <= EPOCH_W'(1);
						state_q <= ST_START;
					end
				end
				ST_START: begin
					count_q <= CNT_W'(1);
					cur_x_q <= sx_q;
					cur_y_q <= sy_q;
					state_q <= ST_EMIT;
				end
				ST_NB: begin
					nb_q <= nb_q + 3'd1;
					if (nb_q[2]) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (pick.found) begin
						if (!count_q[CNT_W-1]) begin
							count_q <= count_q + 1'b1;
						end
						cur_x_q <= pick.x;
						cur_y_q <= pick.y;
						state_q <= ST_EMIT;
					end else begin
						count_q <= count_q - 1'b1;
						if (count_q == CNT_W'(1)) begin
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					cur_x_q <= trail_rd_q[COORD_W-1:0];
					cur_y_q <= trail_rd_q[CELL_W-1:COORD_W];
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_k_s1 <= nb_q[1:0];
		if (emit_go) begin
			out_q <= pend_q;
		end
		if (accept) begin
			rand_q <= cmd.data.rand_value;
			sx_q   <= sx;
			sy_q   <= sy;
			open_q <= '0;
			if (cmd.data.mode) begin
				pend_q <= '{kind: KIND_DONE, from_x: cur_x_q, from_y: cur_y_q,
					to_x: cur_x_q, to_y: cur_y_q};
			end
		end else if (rd_vld_s1) begin
			open_q[rd_k_s1] <= in_grid[rd_k_s1] && (vis_rd_q != epoch_q);
		end
		case (state_q)
			ST_START: begin
				pend_q <= '{kind: KIND_START, from_x: sx_q, from_y: sy_q,
					to_x: sx_q, to_y: sy_q};
			end
			ST_EVAL: begin
				if (pick.found) begin
					pend_q <= '{kind: KIND_EDGE, from_x: cur_x_q, from_y: cur_y_q,
						to_x: pick.x, to_y: pick.y};
				end else begin
					pend_q <= '{kind: KIND_DONE, from_x: cur_x_q, from_y: cur_y_q,
						to_x: cur_x_q, to_y: cur_y_q};
				end
			end
			ST_POP: begin
				pend_q <= '{kind: KIND_BACK, from_x: cur_x_q, from_y: cur_y_q,
					to_x: trail_rd_q[COORD_W-1:0], to_y: trail_rd_q[CELL_W-1:COORD_W]};
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sim/tb_maze_backtracker_walk_core.sv =====
`timescale 1ns / 100ps
// Testbench for maze_backtracker_walk_core: directed and random maze walks, checked item by item
// against an in-bench predictor of the visited map, the trail stack and the current cell.
// Depends on mbw_pkg, mbw_stream_if and the core itself.
module tb_maze_backtracker_walk_core;
	import mbw_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int RANDOM_ITEMS = 700;
	localparam int MANY_STARTS  = 260;
	localparam int DRAIN_LIMIT  = 20000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	mbw_stream_if #(.T(cmd_t)) cmd_ch ();
	mbw_stream_if #(.T(res_t)) res_ch ();

	maze_backtracker_walk_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd_ch),
		.res      (res_ch)
	);

	logic [SIDE_W-1:0] grid_w_reg;
	logic [SIDE_W-1:0] grid_h_reg;
	bit                carved_map [CELLS];
	coord_t            trail_x [CELLS];
	coord_t            trail_y [CELLS];
	int unsigned       trail_depth;
	coord_t            here_x;
	coord_t            here_y;
	res_t              expected_res [$];
	kind_t             last_kind;
	int unsigned       cmds_sent = 0;
	int unsigned       mismatch_count = 0;
	logic              calm = 1'b0;
	logic              hold_res = 1'b0;

	always #4 clk = ~clk;

	function automatic int unsigned side_of(input logic [SIDE_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > SIDE_W'(MAX_SIDE)) begin
			return MAX_SIDE;
		end
		return v;
	endfunction

	function automatic int unsigned cell_of(input int unsigned x, input int unsigned y);
		return (y * MAX_SIDE + x) % CELLS;
	endfunction

	function automatic res_t walk_outcome(input cmd_t c);
		int unsigned w, h, n, pick, sx, sy, fx, fy;
		int unsigned opt_x [4];
		int unsigned opt_y [4];
		res_t r;
		w = side_of(grid_w_reg);
		h = side_of(grid_h_reg);
		fx = here_x;
		fy = here_y;
		r.kind = KIND_DONE;
		r.from_x = here_x;
		r.from_y = here_y;
		r.to_x = here_x;
		r.to_y = here_y;
		if (!c.mode) begin
			sx = (c.start_x > w - 1) ? w - 1 : c.start_x;
			sy = (c.start_y > h - 1) ? h - 1 : c.start_y;
			foreach (carved_map[i]) begin
				carved_map[i] = 1'b0;
			end
			carved_map[cell_of(sx, sy)] = 1'b1;
			trail_x[0] = coord_t'(sx);
			trail_y[0] = coord_t'(sy);
			trail_depth = 1;
			here_x = coord_t'(sx);
			here_y = coord_t'(sy);
			r.kind = KIND_START;
			r.from_x = here_x;
			r.from_y = here_y;
			r.to_x = here_x;
			r.to_y = here_y;
			return r;
		end
		if (trail_depth == 0) begin
			return r;
		end
		n = 0;
		if (fx + 1 < w && !carved_map[cell_of(fx + 1, fy)]) begin
			opt_x[n] = fx + 1;
			opt_y[n] = fy;
			n++;
		end
		if (fy + 1 < h && !carved_map[cell_of(fx, fy + 1)]) begin
			opt_x[n] = fx;
			opt_y[n] = fy + 1;
			n++;
		end
		if (fx > 0 && !carved_map[cell_of(fx - 1, fy)]) begin
			opt_x[n] = fx - 1;
			opt_y[n] = fy;
			n++;
		end
		if (fy > 0 && !carved_map[cell_of(fx, fy - 1)]) begin
			opt_x[n] = fx;
			opt_y[n] = fy - 1;
			n++;
		end
		if (n != 0) begin
			pick = c.rand_value % n;
			carved_map[cell_of(opt_x[pick], opt_y[pick])] = 1'b1;
			here_x = coord_t'(opt_x[pick]);
			here_y = coord_t'(opt_y[pick]);
			if (trail_depth < CELLS) begin
				trail_x[trail_depth] = here_x;
				trail_y[trail_depth] = here_y;
				trail_depth++;
			end
			r.kind = KIND_EDGE;
			r.to_x = here_x;
			r.to_y = here_y;
			return r;
		end
		trail_depth--;
		if (trail_depth == 0) begin
			return r;
		end
		here_x = trail_x[trail_depth - 1];
		here_y = trail_y[trail_depth - 1];
		r.kind = KIND_BACK;
		r.to_x = here_x;
		r.to_y = here_y;
		return r;
	endfunction

	function automatic cmd_t mk_cmd(input logic mode, input int unsigned x, input int unsigned y,
			input int unsigned rv);
		cmd_t c;
		c.mode = mode;
		c.start_x = coord_t'(x);
		c.start_y = coord_t'(y);
		c.rand_value = RAND_W'(rv);
		return c;
	endfunction

	function automatic logic [SIDE_W-1:0] pick_side();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60) begin
			return SIDE_W'($urandom_range(8, 1));
		end
		if (roll < 80) begin
			return SIDE_W'($urandom_range(20, 9));
		end
		if (roll < 88) begin
			return SIDE_W'($urandom_range(64, 21));
		end
		if (roll < 92) begin
			return '0;
		end
		if (roll < 96) begin
			return SIDE_W'(MAX_SIDE);
		end
		return SIDE_W'($urandom_range(127, 65));
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [COORD_W-1:0] got,
			input logic [COORD_W-1:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
		end
	endtask

	task automatic send_cmd(input cmd_t c);
		res_t outcome;
		if (!calm) begin
			while ($urandom_range(99) < 33) begin
				cmd_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		outcome = walk_outcome(c);
		expected_res.insert(expected_res.size(), outcome);
		last_kind = outcome.kind;
		cmds_sent++;
	endtask

	task automatic send_start(input int unsigned x, input int unsigned y);
		send_cmd(mk_cmd(1'b0, x, y, $urandom_range(255)));
	endtask

	task automatic send_step(input int unsigned rv);
		send_cmd(mk_cmd(1'b1, $urandom_range(63), $urandom_range(63), rv));
	endtask

	task automatic walk_steps(input int unsigned budget);
		int unsigned k;
		k = 0;
		do begin
			send_step($urandom_range(255));
			k++;
		end while (last_kind != KIND_DONE && k < budget);
	endtask

	task automatic wait_idle();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_res.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_GRID_WIDTH) begin
			grid_w_reg = val;
		end else begin
			grid_h_reg = val;
		end
		@(posedge clk);
	endtask

	task automatic set_grid(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
		write_reg(CFG_GRID_WIDTH, w);
		write_reg(CFG_GRID_HEIGHT, h);
	endtask

	always @(posedge clk) begin : res_check
		res_t want;
		if (res_ch.valid && res_ch.ready) begin
			if (expected_res.size() == 0) begin
				report_mismatch($sformatf("unexpected result item of kind %0d", res_ch.data.kind));
			end else begin
				want = expected_res.pop_front();
				check_field("kind", res_ch.data.kind, want.kind);
				check_field("from_x", res_ch.data.from_x, want.from_x);
				check_field("from_y", res_ch.data.from_y, want.from_y);
				check_field("to_x", res_ch.data.to_x, want.to_x);
				check_field("to_y", res_ch.data.to_y, want.to_y);
			end
		end
		res_ch.ready <= !hold_res && (calm || $urandom_range(99) >= 33);
	end

	// Before any start the trail is empty, so a step reports finished at the origin.
	task automatic test_reset_state();
		send_step(255);
		send_start(63, 63);
		walk_steps(3);
		wait_idle();
	endtask

	task automatic test_single_cell();
		set_grid(0, 1);
		send_start(63, 0);
		send_step(0);
		send_step(255);
		wait_idle();
	endtask

	task automatic test_largest_grid();
		set_grid(127, 64);
		send_start(63, 63);
		repeat (3) begin
			send_step(0);
			send_step(255);
		end
		send_start(0, 0);
		walk_steps(4);
		wait_idle();
	endtask

	task automatic test_resize_mid_walk();
		set_grid(4, 4);
		send_start(0, 0);
		walk_steps(3);
		wait_idle();
		set_grid(2, 2);
		walk_steps(12);
		wait_idle();
	endtask

	task automatic test_backpressure();
		set_grid(16, 16);
		send_start($urandom_range(63), $urandom_range(63));
		fork
			begin
				hold_res <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_res <= 1'b0;
			end
		join_none
		repeat (40) send_step($urandom_range(255));
		wait_idle();
	endtask

	// Enough starts to wrap the core's record of which clearing pass a mark belongs to.
	task automatic test_many_starts();
		set_grid(3, 3);
		repeat (MANY_STARTS) begin
			send_start($urandom_range(63), $urandom_range(63));
			if ($urandom_range(1) == 1) begin
				send_step($urandom_range(255));
			end
		end
		wait_idle();
	endtask

	task automatic test_random_walks();
		int unsigned base, episode, budget, roll;
		base = cmds_sent;
		episode = 0;
		while (cmds_sent - base < RANDOM_ITEMS) begin
			calm <= (episode >= 12 && episode < 24);
			wait_idle();
			roll = $urandom_range(99);
			if (roll < 15) begin
				repeat ($urandom_range(20, 4)) begin
					if ($urandom_range(99) < 25) begin
						send_start($urandom_range(63), $urandom_range(63));
					end else begin
						send_step($urandom_range(255));
					end
				end
			end else begin
				set_grid(pick_side(), pick_side());
				budget = 2 * side_of(grid_w_reg) * side_of(grid_h_reg) + 2;
				budget = (budget > 250) ? 250 : budget;
				send_start($urandom_range(63), $urandom_range(63));
				if (roll < 30) begin
					walk_steps(budget / 2 + 1);
					wait_idle();
					set_grid(pick_side(), pick_side());
					budget = 2 * side_of(grid_w_reg) * side_of(grid_h_reg) + 2;
					budget = (budget > 250) ? 250 : budget;
				end
				walk_steps(budget);
				if ($urandom_range(3) == 0) begin
					send_step($urandom_range(255));
				end
			end
			episode++;
		end
		wait_idle();
	endtask

	initial begin
		int unsigned waited;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		res_ch.ready = 1'b0;
		grid_w_reg = SIDE_RESET;
		grid_h_reg = SIDE_RESET;
		trail_depth = 0;
		here_x = '0;
		here_y = '0;
		last_kind = KIND_DONE;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_single_cell();
		test_largest_grid();
		test_resize_mid_walk();
		test_backpressure();
		test_many_starts();
		test_random_walks();
		cmd_ch.valid <= 1'b0;
		waited = 0;
		while (expected_res.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (expected_res.size() != 0) begin
			report_mismatch($sformatf("%0d result items never arrived", expected_res.size()));
		end
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
